// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the core clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CVPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cvps check failed");
`define CVPS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("cvps forbidden condition seen");
`else
`define CVPS_ASSERT(lbl, prop)
`define CVPS_NEVER(lbl, cond)
`endif
`endif

// ----- src/cvps_pkg.sv -----
// ----------------------------------------------------------------------------
// cvps_pkg
// shared types, constants and helpers of the cosine profile solver
// ----------------------------------------------------------------------------
package cvps_pkg;

    localparam int DIV_W = 64;
    localparam int DSR_W = 33;
    localparam int ROUND_LIMIT = 4096;
    localparam int ROUND_W = 13;
    localparam logic [30:0] TIME_TOP = 31'h7FFF_FFFF;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [2:0] REG_SPEED_MAX  = 3'd0;
    localparam logic [2:0] REG_SPEED_MIN  = 3'd1;
    localparam logic [2:0] REG_ACCEL_MAX  = 3'd2;
    localparam logic [2:0] REG_TIME_STEP  = 3'd3;
    localparam logic [2:0] REG_BASE_RATIO = 3'd4;

    localparam logic [2:0] MODE_CALIB    = 3'd0;
    localparam logic [2:0] MODE_GIVEN    = 3'd1;
    localparam logic [2:0] MODE_NO_RISE  = 3'd3;
    localparam logic [2:0] MODE_NO_FALL  = 3'd4;

    typedef enum logic [1:0] {
        SHAPE_THREE,
        SHAPE_NO_RISE,
        SHAPE_NO_FALL
    } t_shape;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_LOOP,
        S_T1_GO,
        S_T1_WAIT,
        S_MUL_A,
        S_MUL_B,
        S_VM_SUB,
        S_VM_GO,
        S_VM_WAIT,
        S_ACC_CHK,
        S_ACC_GO,
        S_ACC_WAIT,
        S_ACC_MUL,
        S_ACC_FIN,
        S_DECIDE,
        S_END,
        S_CAL_MUL,
        S_CAL_GO,
        S_CAL_WAIT,
        S_DONE
    } t_state;

    // signed saturation of a magnitude with a separate sign
    function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic [63:0] nm;
        nm = -mag;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) return 32'sh8000_0000;
            return $signed(nm[31:0]);
        end
        if (mag > 64'h0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        return $signed(mag[31:0]);
    endfunction

    function automatic logic [30:0] clamp_ratio(input logic [63:0] r);
        if (r == 64'd0) return 31'd1;
        if (r > {33'd0, TIME_TOP}) return TIME_TOP;
        return r[30:0];
    endfunction

endpackage

// ----- src/cvps_div.sv -----
// ----------------------------------------------------------------------------
// cvps_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cvps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cvps_pkg::DIV_W-1:0]    i_dividend,
    input  logic [cvps_pkg::DSR_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [cvps_pkg::DIV_W-1:0]    o_quot
);
    import cvps_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_dsr;
    logic [DSR_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] diff;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DSR_W+1]) begin
                r_rem <= diff[DSR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DSR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- src/cosine_velocity_profile_solver_core.sv -----
// ----------------------------------------------------------------------------
// cosine_velocity_profile_solver_core
// search for a three-segment raised-cosine speed profile, q16.16
// ----------------------------------------------------------------------------
// channel   dir  handshake          content
// s_*       in   s_tvalid/s_tready  move request, plan_mode on s_tuser
// m_*       out  m_tvalid/m_tready  solved profile
// apb       in   psel/penable       limit and step registers
//
// each search round runs up to four divisions on the shared divider plus
// multiplies; when the ratio is calibrated first, the search runs twice
// over. the search stops after at most 4096 rounds. s_tready is high only
// when idle; a finished result waits in the output register while the next
// move runs. reset is synchronous and restores the register defaults.
`include "assert_macros.svh"

module cosine_velocity_profile_solver_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // distance, move_time, start_speed, goal_speed, ratio_in
    input  logic [159:0] s_tdata,
    // plan_mode
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // total_time, cruise_speed, rise_time, cruise_time, fall_time,
    // rise_accel, fall_accel, ratio_used
    output logic [255:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cvps_pkg::*;

    localparam logic [32:0] ONE_Q = 33'(1) << FRAC_BITS;

    // configuration
    logic [30:0]        r_speed_max;
    logic signed [31:0] r_speed_min;
    logic [30:0]        r_accel_max;
    logic [30:0]        r_time_step;
    logic [30:0]        r_base_ratio;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_max  <= 31'd131072;
            r_speed_min  <= 32'sd0;
            r_accel_max  <= 31'd65536;
            r_time_step  <= 31'd655;
            r_base_ratio <= 31'd65536;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_SPEED_MAX:  r_speed_max  <= pwdata[30:0];
                REG_SPEED_MIN:  r_speed_min  <= $signed(pwdata);
                REG_ACCEL_MAX:  r_accel_max  <= pwdata[30:0];
                REG_TIME_STEP:  r_time_step  <= pwdata[30:0];
                REG_BASE_RATIO: r_base_ratio <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SPEED_MAX:  prdata = {1'b0, r_speed_max};
            REG_SPEED_MIN:  prdata = r_speed_min;
            REG_ACCEL_MAX:  prdata = {1'b0, r_accel_max};
            REG_TIME_STEP:  prdata = {1'b0, r_time_step};
            REG_BASE_RATIO: prdata = {1'b0, r_base_ratio};
            default:        prdata = 32'd0;
        endcase
    end

    // request fields
    logic signed [31:0] in_dist, in_vs, in_vg;
    logic [30:0]        in_time, in_ratio;
    assign in_dist  = $signed(s_tdata[31:0]);
    assign in_time  = s_tdata[62:32];
    assign in_vs    = $signed(s_tdata[94:63]);
    assign in_vg    = $signed(s_tdata[126:95]);
    assign in_ratio = s_tdata[157:127];

    // working registers
    t_state             r_state, n_state;
    t_shape             r_shape;
    logic               r_calib;
    logic               r_which;
    logic               r_neg;
    logic [ROUND_W-1:0] r_rounds;
    logic signed [31:0] r_s, r_vs, r_vg;
    logic [30:0]        r_t0, r_t, r_t1, r_t3, r_k;
    logic [31:0]        r_t2;
    logic signed [31:0] r_vm, r_a1, r_a3, r_q;
    logic signed [65:0] r_num;
    logic signed [67:0] r_prod;

    // output register
    logic               r_out_valid;
    logic [255:0]       r_out_data;

    // divider
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quot;
    logic [DSR_W-1:0]   div_divisor;

    cvps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // derived values
    logic               s_accept;
    logic               run_on;
    logic [30:0]        d_len;
    logic [32:0]        t_sum;
    logic signed [32:0] dv_a1, dv_a3, dv_sel, dv_g;
    logic [32:0]        dv_mag, n_mag, d_mag;
    logic [30:0]        len_sel;
    logic [32:0]        a1_mag, a3_mag, q_mag;
    logic               accel_ok, in_win, over_max;
    logic [31:0]        t_grow;
    logic [30:0]        t_next;
    logic [65:0]        num_mag;
    logic signed [65:0] s_shift;
    logic [30:0]        q_t1;
    logic signed [33:0] mul_a, mul_b;
    logic [2:0]         in_mode;
    logic [30:0]        in_t0;

    assign s_accept = s_tvalid && s_tready;
    assign in_mode  = s_tuser;
    assign in_t0    = (in_time == 31'd0) ? 31'd1 : in_time;
    assign run_on   = (r_t2 < {1'b0, r_t}) && (r_rounds < ROUND_W'(ROUND_LIMIT));
    assign d_len    = 31'({1'b0, r_t} - r_t2);
    assign t_sum    = {2'b00, r_t} + {1'b0, r_t2};
    assign dv_a1    = {r_vm[31], r_vm} - {r_vs[31], r_vs};
    assign dv_a3    = {r_vg[31], r_vg} - {r_vm[31], r_vm};
    assign dv_sel   = r_which ? dv_a3 : dv_a1;
    assign dv_mag   = dv_sel[32] ? 33'(-dv_sel) : 33'(dv_sel);
    assign len_sel  = r_which ? r_t3 : r_t1;
    assign dv_g     = dv_a3;
    assign n_mag    = dv_g[32] ? 33'(-dv_g) : 33'(dv_g);
    assign d_mag    = dv_a1[32] ? 33'(-dv_a1) : 33'(dv_a1);
    assign a1_mag   = r_a1[31] ? 33'(-{r_a1[31], r_a1}) : {1'b0, r_a1};
    assign a3_mag   = r_a3[31] ? 33'(-{r_a3[31], r_a3}) : {1'b0, r_a3};
    assign q_mag    = r_q[31] ? 33'(-{r_q[31], r_q}) : {1'b0, r_q};
    assign accel_ok = (a1_mag <= {2'b00, r_accel_max}) && (a3_mag <= {2'b00, r_accel_max});
    assign over_max = $signed({r_vm[31], r_vm}) > $signed({2'b00, r_speed_max});
    assign in_win   = !over_max && (r_vm >= r_speed_min);
    assign t_grow   = {1'b0, r_t} + {1'b0, r_time_step};
    assign t_next   = t_grow[31] ? TIME_TOP : t_grow[30:0];
    assign num_mag  = r_num[65] ? 66'(-r_num) : 66'(r_num);
    assign s_shift  = 66'(signed'(r_s)) <<< (FRAC_BITS + 1);
    assign q_t1     = div_quot[30:0];

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_MUL_A: begin
                mul_a = $signed({3'b000, r_t1});
                mul_b = 34'(signed'(r_vs));
            end
            S_MUL_B: begin
                mul_a = $signed({3'b000, r_t3});
                mul_b = 34'(signed'(r_vg));
            end
            S_ACC_MUL: begin
                mul_a = $signed({1'b0, q_mag});
                mul_b = $signed({3'b000, HALF_PI_Q30});
            end
            S_CAL_MUL: begin
                mul_a = $signed({3'b000, r_k});
                mul_b = $signed({1'b0, n_mag});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_T1_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({33'd0, d_len}) << FRAC_BITS;
                div_divisor  = {2'b00, r_k} + ONE_Q;
            end
            S_VM_GO: begin
                div_start    = 1'b1;
                div_dividend = num_mag[63:0];
                div_divisor  = t_sum;
            end
            S_ACC_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({31'd0, dv_mag}) << FRAC_BITS;
                div_divisor  = {2'b00, len_sel};
            end
            S_CAL_GO: begin
                div_start    = 1'b1;
                div_dividend = r_prod[63:0];
                div_divisor  = d_mag;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state  = r_state;
        s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_mode == MODE_CALIB || in_mode == MODE_GIVEN ||
                        in_mode == MODE_NO_RISE || in_mode == MODE_NO_FALL) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INIT: n_state = S_LOOP;
            S_LOOP: begin
                if (!run_on)                    n_state = S_END;
                else if (r_shape == SHAPE_THREE) n_state = S_T1_GO;
                else                            n_state = S_MUL_A;
            end
            S_T1_GO:   n_state = S_T1_WAIT;
            S_T1_WAIT: if (div_done) n_state = S_MUL_A;
            S_MUL_A:   n_state = S_MUL_B;
            S_MUL_B:   n_state = S_VM_SUB;
            S_VM_SUB:  n_state = S_VM_GO;
            S_VM_GO:   n_state = S_VM_WAIT;
            S_VM_WAIT: if (div_done) n_state = S_ACC_CHK;
            S_ACC_CHK: begin
                if (len_sel != 31'd0) n_state = S_ACC_GO;
                else if (r_which)     n_state = S_DECIDE;
            end
            S_ACC_GO:   n_state = S_ACC_WAIT;
            S_ACC_WAIT: if (div_done) n_state = S_ACC_MUL;
            S_ACC_MUL:  n_state = S_ACC_FIN;
            S_ACC_FIN:  n_state = r_which ? S_DECIDE : S_ACC_CHK;
            S_DECIDE:   n_state = (in_win && accel_ok) ? S_END : S_LOOP;
            S_END: begin
                if (!r_calib)                          n_state = S_DONE;
                else if (r_vm == r_vs || r_vm == r_vg) n_state = S_INIT;
                else                                   n_state = S_CAL_MUL;
            end
            S_CAL_MUL:  n_state = S_CAL_GO;
            S_CAL_GO:   n_state = S_CAL_WAIT;
            S_CAL_WAIT: if (div_done) n_state = S_INIT;
            S_DONE:     if (!r_out_valid || m_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_s   <= in_dist;
                        r_vs  <= in_vs;
                        r_vg  <= in_vg;
                        r_t0  <= in_t0;
                        r_calib <= (in_mode == MODE_CALIB);
                        r_shape <= SHAPE_THREE;
                        r_k     <= 31'd0;
                        // constant move, no search
                        r_t  <= in_t0;
                        r_t2 <= {1'b0, in_t0};
                        r_t1 <= 31'd0;
                        r_t3 <= 31'd0;
                        r_vm <= in_vs;
                        r_a1 <= 32'sd0;
                        r_a3 <= 32'sd0;
                        case (in_mode)
                            MODE_CALIB:   r_k <= clamp_ratio({33'd0, r_base_ratio});
                            MODE_GIVEN:   r_k <= clamp_ratio({33'd0, in_ratio});
                            MODE_NO_RISE: r_shape <= SHAPE_NO_RISE;
                            MODE_NO_FALL: r_shape <= SHAPE_NO_FALL;
                            default: ;
                        endcase
                    end
                end
                S_INIT: begin
                    r_t      <= r_t0;
                    r_t2     <= 32'd0;
                    r_t1     <= 31'd0;
                    r_t3     <= 31'd0;
                    r_vm     <= 32'sd0;
                    r_a1     <= 32'sd0;
                    r_a3     <= 32'sd0;
                    r_rounds <= '0;
                end
                S_LOOP: begin
                    if (run_on) begin
                        r_rounds <= r_rounds + 1'b1;
                        if (r_shape == SHAPE_NO_RISE) begin
                            r_t1 <= 31'd0;
                            r_t3 <= d_len;
                        end else if (r_shape == SHAPE_NO_FALL) begin
                            r_t1 <= d_len;
                            r_t3 <= 31'd0;
                        end
                    end
                end
                S_T1_WAIT: begin
                    if (div_done) begin
                        r_t1 <= q_t1;
                        r_t3 <= d_len - q_t1;
                    end
                end
                S_MUL_B:  r_num <= s_shift - $signed(r_prod[65:0]);
                S_VM_SUB: r_num <= r_num - $signed(r_prod[65:0]);
                S_VM_GO:  r_neg <= r_num[65];
                S_VM_WAIT: begin
                    if (div_done) begin
                        r_vm    <= sat_mag(div_quot, r_neg);
                        r_which <= 1'b0;
                    end
                end
                S_ACC_CHK: begin
                    r_neg <= dv_sel[32];
                    if (len_sel == 31'd0) begin
                        if (r_which) r_a3 <= 32'sd0;
                        else         r_a1 <= 32'sd0;
                        r_which <= 1'b1;
                    end
                end
                S_ACC_WAIT: if (div_done) r_q <= sat_mag(div_quot, r_neg);
                S_ACC_FIN: begin
                    // drop the q30 fraction of the pi/2 scaling
                    if (r_which) r_a3 <= sat_mag({30'd0, r_prod[63:30]}, r_neg);
                    else         r_a1 <= sat_mag({30'd0, r_prod[63:30]}, r_neg);
                    r_which <= 1'b1;
                end
                S_DECIDE: begin
                    if (in_win) begin
                        if (!accel_ok) r_t <= t_next;
                    end else if (over_max && accel_ok) begin
                        r_t2 <= 32'(r_t2 + {1'b0, r_time_step});
                    end else begin
                        r_t <= t_next;
                    end
                end
                S_END: if (r_calib && (r_vm == r_vs || r_vm == r_vg)) r_calib <= 1'b0;
                S_CAL_WAIT: begin
                    if (div_done) begin
                        r_k     <= clamp_ratio(div_quot);
                        r_calib <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || m_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || m_tready)) begin
            r_out_data <= {5'd0, r_k, r_a3, r_a1, r_t3,
                           (r_t2[31] ? TIME_TOP : r_t2[30:0]), r_t1, r_vm, r_t};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // checks
    `CVPS_ASSERT(a_accept_leaves_idle, s_accept |=> (r_state != S_IDLE))
    `CVPS_NEVER(a_rounds_bound, r_rounds > ROUND_W'(ROUND_LIMIT))
    `CVPS_ASSERT(a_div_done_in_wait, div_done |-> (r_state == S_T1_WAIT ||
        r_state == S_VM_WAIT || r_state == S_ACC_WAIT || r_state == S_CAL_WAIT))

endmodule
